// File: hdl/brad_pkg.sv
// Shared widths, types and sequencer states of the bounding radius block.
package brad_pkg;

  localparam int MAX_VERTICES = 4096;

  localparam int COORD_W    = 16;
  localparam int DIST_W     = 16;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_CW    = $clog2(SQRT_STEPS);
  localparam int DIV_CW     = $clog2(DIV_STEPS);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam sum_t SUM_LIMIT = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_RSTART,
    ST_RWAIT,
    ST_ACC,
    ST_DSTART,
    ST_DWAIT,
    ST_DONE
  } brad_state_t;

endpackage

// File: hdl/brad_sqrt.sv
// Bit-serial floor square root: two radicand bits in, one root bit out per cycle.
module brad_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  brad_pkg::sq_t   radicand,
  output logic            done,
  output brad_pkg::dist_t root
);

  logic                                run_r;
  logic                                done_r;
  logic [brad_pkg::SQRT_CW-1:0]        step_r;
  brad_pkg::sq_t                       rad_r;
  logic [brad_pkg::DIST_W:0]           rem_r;
  brad_pkg::dist_t                     root_r;

  logic [brad_pkg::DIST_W+2:0]         rem_sh;
  logic [brad_pkg::DIST_W+2:0]         trial;
  logic [brad_pkg::DIST_W+2:0]         rem_diff;
  logic                                fits;
  logic                                last_step;

  // Bring down the next radicand pair and try root*4+1 against the remainder.
  assign rem_sh    = {rem_r, rad_r[brad_pkg::SQ_W-1 -: 2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign fits      = (rem_sh >= trial);
  assign rem_diff  = fits ? (rem_sh - trial) : rem_sh;
  assign last_step = (step_r == brad_pkg::SQRT_CW'(brad_pkg::SQRT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r && last_step;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[brad_pkg::SQ_W-3:0], 2'b00};
      rem_r  <= rem_diff[brad_pkg::DIST_W:0];
      root_r <= {root_r[brad_pkg::DIST_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hdl/brad_div.sv
// Bit-serial restoring divider: one quotient bit per cycle for the average.
module brad_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  brad_pkg::sum_t dividend,
  input  brad_pkg::cnt_t divisor,
  output logic           done,
  output brad_pkg::sum_t quotient
);

  logic                        run_r;
  logic                        done_r;
  logic [brad_pkg::DIV_CW-1:0] step_r;
  brad_pkg::sum_t              quo_r;
  brad_pkg::cnt_t              rem_r;
  brad_pkg::cnt_t              dvs_r;

  logic [brad_pkg::CNT_W:0]    rem_sh;
  logic [brad_pkg::CNT_W:0]    rem_diff;
  logic                        fits;
  logic                        last_step;

  // Shift the next dividend bit into the remainder; subtract when it fits.
  assign rem_sh    = {rem_r, quo_r[brad_pkg::SUM_W-1]};
  assign fits      = (rem_sh >= {1'b0, dvs_r});
  assign rem_diff  = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  assign last_step = (step_r == brad_pkg::DIV_CW'(brad_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r && last_step;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[brad_pkg::SUM_W-2:0], fits};
      rem_r <= rem_diff[brad_pkg::CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/bounding_radius_avg_max_top.sv
// Bounding sphere radius: mean and peak vertex distance over a vertex set.
//
// Input channel in_*: one vertex per item, signed Q8.8 x, y, z in in_tdata and
// in_tlast marking the final vertex of the set. Result channel out_*: one item
// per set, sent after the vertex marked last, holding the truncated mean and
// the peak distance (unsigned Q8.8) and the overflow flag in out_tuser.
// A set longer than MAX_VERTICES vertices saturates the count; the extra
// vertices still count toward the peak and raise overflow.
//
// Each vertex is taken in the accept state, squared one coordinate at a time on
// the shared 16x16 squarer, rooted by the bit-serial square root (16 root bits)
// once started, and then accumulated; no new vertex is taken meanwhile. After the
// last vertex the block starts the bit-serial divider (28 quotient bits) and,
// once it is done, loads the output register, which raises out_tvalid.
//
// The output register holds a result until out_tready; new vertices are taken
// meanwhile, and only a following result waits in the done state for the
// register to drain. Reset (rst_n low, synchronous) clears the sums, count,
// peak, overflow and any pending result.
module bounding_radius_avg_max_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x [15:0], pos_y [31:16], pos_z [47:32]
  input  logic        in_tlast,   // last_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mean distance [15:0], peak distance [31:16]
  output logic        out_tuser   // overflow
);

  brad_pkg::brad_state_t state_r;
  brad_pkg::brad_state_t state_nxt;

  brad_pkg::coord_t x_r;
  brad_pkg::coord_t y_r;
  brad_pkg::coord_t z_r;
  logic             last_r;
  logic [1:0]       sq_idx_r;
  brad_pkg::sq_t    sq_acc_r;

  brad_pkg::sum_t   sum_r;
  brad_pkg::dist_t  max_r;
  brad_pkg::cnt_t   cnt_r;
  logic             ovf_r;

  logic             out_valid_r;
  brad_pkg::dist_t  out_avg_r;
  brad_pkg::dist_t  out_max_r;
  logic             out_ovf_r;

  logic             sqrt_start;
  logic             sqrt_done;
  brad_pkg::dist_t  vtx_dist;
  logic             div_start;
  logic             div_done;
  brad_pkg::sum_t   quot;
  logic             out_load;

  brad_pkg::coord_t coord_sel;
  brad_pkg::coord_t coord_abs;
  brad_pkg::sq_t    coord_sq;
  logic [brad_pkg::SUM_W:0] sum_add;

  always_comb begin
    unique case (sq_idx_r)
      2'd0:    coord_sel = x_r;
      2'd1:    coord_sel = y_r;
      default: coord_sel = z_r;
    endcase
  end

  // Two's complement negate also maps -32768 to the magnitude 32768.
  assign coord_abs = coord_sel[brad_pkg::COORD_W-1] ? (~coord_sel + 1'b1) : coord_sel;
  assign coord_sq  = coord_abs * coord_abs;
  assign sum_add   = {1'b0, sum_r} +
                     {{(brad_pkg::SUM_W - brad_pkg::DIST_W + 1){1'b0}}, vtx_dist};

  brad_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_acc_r),
    .done     (sqrt_done),
    .root     (vtx_dist)
  );

  brad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brad_pkg::ST_IDLE:   if (in_tvalid) state_nxt = brad_pkg::ST_SQ;
      brad_pkg::ST_SQ:     if (sq_idx_r == 2'd2) state_nxt = brad_pkg::ST_RSTART;
      brad_pkg::ST_RSTART: state_nxt = brad_pkg::ST_RWAIT;
      brad_pkg::ST_RWAIT:  if (sqrt_done) state_nxt = brad_pkg::ST_ACC;
      brad_pkg::ST_ACC:    state_nxt = last_r ? brad_pkg::ST_DSTART : brad_pkg::ST_IDLE;
      brad_pkg::ST_DSTART: state_nxt = brad_pkg::ST_DWAIT;
      brad_pkg::ST_DWAIT:  if (div_done) state_nxt = brad_pkg::ST_DONE;
      brad_pkg::ST_DONE:   if (!out_valid_r) state_nxt = brad_pkg::ST_IDLE;
      default:             state_nxt = brad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == brad_pkg::ST_IDLE);
    sqrt_start = (state_r == brad_pkg::ST_RSTART);
    div_start  = (state_r == brad_pkg::ST_DSTART);
    out_load   = (state_r == brad_pkg::ST_DONE) && !out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brad_pkg::ST_IDLE;
      sq_idx_r    <= '0;
      sum_r       <= '0;
      max_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == brad_pkg::ST_IDLE) begin
        sq_idx_r <= '0;
      end else if (state_r == brad_pkg::ST_SQ) begin
        sq_idx_r <= sq_idx_r + 1'b1;
      end

      if (state_r == brad_pkg::ST_ACC) begin
        if (cnt_r >= brad_pkg::cnt_t'(brad_pkg::MAX_VERTICES)) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          // Saturate on carry out of the sum.
          sum_r <= sum_add[brad_pkg::SUM_W] ? brad_pkg::SUM_LIMIT
                                            : sum_add[brad_pkg::SUM_W-1:0];
        end
        if (vtx_dist > max_r) begin
          max_r <= vtx_dist;
        end
      end

      if (out_load) begin
        sum_r <= '0;
        max_r <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r    <= in_tdata[15:0];
      y_r    <= in_tdata[31:16];
      z_r    <= in_tdata[47:32];
      last_r <= in_tlast;
    end
    if (state_r == brad_pkg::ST_IDLE) begin
      sq_acc_r <= '0;
    end else if (state_r == brad_pkg::ST_SQ) begin
      sq_acc_r <= sq_acc_r + coord_sq;
    end
    if (out_load) begin
      out_avg_r <= (cnt_r != '0) ? quot[brad_pkg::DIST_W-1:0] : '0;
      out_max_r <= max_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_max_r, out_avg_r};
  assign out_tuser  = out_ovf_r;

endmodule

// File: hdl/brad_checker.sv
// Port-level checks for the bounding radius block, bound to the top level.
module brad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  // Drop any pending result on reset.
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The average never exceeds the maximum.
  a_avg_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:16] >= out_tdata[15:0])
    else $error("average above maximum");

  // A vertex occupies the datapath; no accept in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A fresh result only follows a vertex marked last.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("result without a last vertex");

endmodule

bind bounding_radius_avg_max_top brad_checker u_brad_checker (.*);

// File: tb/tb_bounding_radius_avg_max_top.sv
`timescale 1ns / 1ps
// Testbench for bounding_radius_avg_max_top: vertex sets in, per-set radius results checked.
module tb_bounding_radius_avg_max_top;

  typedef struct {
    brad_pkg::coord_t x;
    brad_pkg::coord_t y;
    brad_pkg::coord_t z;
    logic             last;
    int               gap;
    bit               drain;
  } vertex_t;

  typedef struct {
    brad_pkg::dist_t mean_dist;
    brad_pkg::dist_t peak_dist;
    logic            overflow;
  } radius_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  bounding_radius_avg_max_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  vertex_t vertex_q[$];
  radius_t radius_q[$];

  // predictor state
  brad_pkg::sum_t  dist_sum = '0;
  brad_pkg::dist_t dist_peak = '0;
  int              vert_count = 0;
  logic            ovf_seen = 1'b0;

  int      sets_sent = 0;
  int      sets_got = 0;
  int      fail_count = 0;
  vertex_t cur_vertex;
  bit      have_item = 0;
  int      gap_left = 0;
  int      stall_left = 0;

  function automatic brad_pkg::dist_t floor_sqrt32(brad_pkg::sq_t v);
    brad_pkg::sq_t root;
    brad_pkg::sq_t probe;
    root = '0;
    probe = 32'h4000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[brad_pkg::DIST_W-1:0];
  endfunction

  function automatic brad_pkg::sq_t coord_square(brad_pkg::coord_t c);
    int          s;
    int unsigned m;
    s = $signed(c);
    m = (s < 0) ? -s : s;
    return m * m;
  endfunction

  // Advance the running sum, peak and count by one accepted vertex.
  task automatic fold_vertex(input vertex_t v);
    brad_pkg::dist_t          vtx_dist;
    logic [brad_pkg::SUM_W:0] grown;
    radius_t                  r;
    vtx_dist = floor_sqrt32(coord_square(v.x) + coord_square(v.y) + coord_square(v.z));
    if (vert_count >= brad_pkg::MAX_VERTICES) begin
      ovf_seen = 1'b1;
    end else begin
      vert_count++;
      grown = {1'b0, dist_sum} + vtx_dist;
      if (grown > brad_pkg::SUM_LIMIT) dist_sum = brad_pkg::SUM_LIMIT;
      else dist_sum = grown[brad_pkg::SUM_W-1:0];
    end
    if (vtx_dist > dist_peak) dist_peak = vtx_dist;
    if (v.last) begin
      r.mean_dist = (vert_count != 0) ? brad_pkg::dist_t'(dist_sum / vert_count) : '0;
      r.peak_dist = dist_peak;
      r.overflow  = ovf_seen;
      radius_q.push_back(r);
      sets_sent++;
      dist_sum = '0;
      dist_peak = '0;
      vert_count = 0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic queue_vertex(input int x, input int y, input int z, input logic last,
                              input int gap, input bit drain);
    vertex_t v;
    v.x = brad_pkg::coord_t'(x);
    v.y = brad_pkg::coord_t'(y);
    v.z = brad_pkg::coord_t'(z);
    v.last = last;
    v.gap = gap;
    v.drain = drain;
    vertex_q.push_back(v);
  endtask

  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, 65535);
    if (pick < 8) return $urandom_range(0, 600) - 300;
    unique case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return -1;
      3: return 1;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      have_item = 0;
      gap_left = 0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        fold_vertex(cur_vertex);
        busy = 0;
      end
      // a drain item waits until every set sent so far has its result back
      if (!busy && !have_item && vertex_q.size() > 0 &&
          !(vertex_q[0].drain && sets_sent != sets_got)) begin
        cur_vertex = vertex_q.pop_front();
        gap_left = cur_vertex.gap;
        have_item = 1;
      end
      if (!busy && have_item) begin
        if (gap_left == 0) begin
          in_tdata <= {cur_vertex.z, cur_vertex.y, cur_vertex.x};
          in_tlast <= cur_vertex.last;
          busy = 1;
          have_item = 0;
        end else begin
          gap_left--;
        end
      end
      in_tvalid <= busy;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic    nxt_ready;
    radius_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 19);
    end else begin
      nxt_ready = out_tready;
      if (out_tvalid && out_tready) begin
        if (radius_q.size() == 0) begin
          $error("result with none expected: mean_dist %0d peak_dist %0d overflow %0d",
                 out_tdata[15:0], out_tdata[31:16], out_tuser);
          fail_count++;
        end else begin
          want = radius_q.pop_front();
          sets_got <= sets_got + 1;
          if (out_tdata[15:0] !== want.mean_dist) begin
            $error("mean_dist expected %0d got %0d", want.mean_dist, out_tdata[15:0]);
            fail_count++;
          end
          if (out_tdata[31:16] !== want.peak_dist) begin
            $error("peak_dist expected %0d got %0d", want.peak_dist, out_tdata[31:16]);
            fail_count++;
          end
          if (out_tuser !== want.overflow) begin
            $error("overflow expected %0d got %0d", want.overflow, out_tuser);
            fail_count++;
          end
        end
        stall_left = $urandom_range(0, 19);
        nxt_ready = (stall_left == 0);
      end else if (!out_tready) begin
        if (stall_left > 0) stall_left--;
        nxt_ready = (stall_left == 0);
      end
      out_tready <= nxt_ready;
    end
  end

  initial begin
    int  n;
    int  len;
    // single vertices: origin, extremes, one axis at a time
    queue_vertex(0, 0, 0, 1, $urandom_range(0, 19), 0);
    queue_vertex(-32768, -32768, -32768, 1, $urandom_range(0, 19), 0);
    queue_vertex(32767, 32767, 32767, 1, $urandom_range(0, 19), 0);
    queue_vertex(-32768, 0, 0, 1, $urandom_range(0, 19), 0);
    queue_vertex(0, 32767, 0, 1, $urandom_range(0, 19), 0);
    queue_vertex(0, 0, -1, 1, $urandom_range(0, 19), 0);
    // truncated average over a short set
    queue_vertex(3, 4, 0, 0, $urandom_range(0, 19), 0);
    queue_vertex(-3, 0, -4, 0, $urandom_range(0, 19), 0);
    queue_vertex(1, 0, 0, 1, $urandom_range(0, 19), 0);
    // peak in the middle of a set
    queue_vertex(255, -255, 255, 0, $urandom_range(0, 19), 0);
    queue_vertex(-32768, -32768, -32768, 0, $urandom_range(0, 19), 0);
    queue_vertex(0, 0, 0, 0, $urandom_range(0, 19), 0);
    queue_vertex(0, 0, -32768, 1, $urandom_range(0, 19), 0);
    queue_vertex(-1, -1, -1, 0, $urandom_range(0, 19), 0);
    queue_vertex(1, 1, 1, 1, $urandom_range(0, 19), 0);

    n = 0;
    while (n < 900) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        queue_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1,
                     $urandom_range(0, 19),
                     i == 0 && (n == 0 || $urandom_range(0, 24) == 0));
      end
      n += len;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (vertex_q.size() != 0 || have_item || in_tvalid || sets_got != sets_sent);
    // let any stray result show up
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
